>>> src/wlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_pkg
// Shared widths, constants, register codes and tables of the wall line block.
// ----------------------------------------------------------------------------
package wlr_pkg;

   localparam int RANGE_W   = 16;
   localparam int ICPT_W    = 24;
   localparam int HEAD_W    = 15;
   localparam int GAP_W     = 20;
   localparam int CSR_IDX_W = 3;
   localparam int ICPT_QB   = 23;   // quotient bits of intercept divider
   localparam int GAP_QB    = 20;   // quotient bits of gap divider
   localparam int CORDIC_N  = 16;
   localparam int ZW        = 26;   // angle accumulator, 2^-16 degree

   // Q0.15 cos/sin of 20 and 70 degrees
   localparam logic [14:0] K_BIG   = 15'd30792;
   localparam logic [14:0] K_SMALL = 15'd11207;

   localparam logic [ICPT_QB-1:0] INTERCEPT_MAX = 23'd8388607;
   localparam logic [GAP_W-1:0]   GAP_MAX       = 20'd1048575;
   localparam int                 HEADING_MAX   = 11520;
   localparam int                 SENTINEL_MM   = 9999;
   localparam int                 HALF_TURN     = 180 * 65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_MIN_VALID = 3'd0,
      CFG_MAX_RANGE = 3'd1,
      CFG_ERR_CODE  = 3'd2,
      CFG_MAX_DIFF  = 3'd3,
      CFG_VERT_EPS  = 3'd4
   } cfg_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] min_valid;
      logic [RANGE_W-1:0] max_range;
      logic [RANGE_W-1:0] err_code;
      logic [RANGE_W-1:0] max_diff;
      logic [RANGE_W-1:0] vert_eps;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Word of one side between front and back: ok, neg, a, b, |c|, |b|, a^2+b^2
   function automatic int side_w(input int frac);
      int csw;
      csw = 18 + frac;
      return 2 + 2 * (csw + 1) + (2 * csw + 1) + csw + (2 * csw + 1);
   endfunction

   // atan(2^-i) in 2^-16 degree
   function automatic logic [21:0] atan_entry(input logic [3:0] i);
      logic [21:0] v;
      case (i)
         4'd0:    v = 22'd2949120;
         4'd1:    v = 22'd1740967;
         4'd2:    v = 22'd919879;
         4'd3:    v = 22'd466945;
         4'd4:    v = 22'd234379;
         4'd5:    v = 22'd117304;
         4'd6:    v = 22'd58666;
         4'd7:    v = 22'd29335;
         4'd8:    v = 22'd14668;
         4'd9:    v = 22'd7334;
         4'd10:   v = 22'd3667;
         4'd11:   v = 22'd1833;
         4'd12:   v = 22'd917;
         4'd13:   v = 22'd458;
         4'd14:   v = 22'd229;
         default: v = 22'd115;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> src/wlr_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_req_if
// Request channel: four range readings per word.
// ----------------------------------------------------------------------------
interface wlr_req_if import wlr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] left_far_range;
   logic [RANGE_W-1:0] left_near_range;
   logic [RANGE_W-1:0] right_near_range;
   logic [RANGE_W-1:0] right_far_range;

   modport source (output valid, left_far_range, left_near_range, right_near_range,
                   right_far_range, input ready);
   modport sink   (input valid, left_far_range, left_near_range, right_near_range,
                   right_far_range, output ready);
endinterface
`default_nettype wire

>>> src/wlr_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_rsp_if
// Response channel: fitted line of each side.
// ----------------------------------------------------------------------------
interface wlr_rsp_if import wlr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     left_ok;
   logic signed [ICPT_W-1:0] left_intercept;
   logic signed [HEAD_W-1:0] left_heading;
   logic [GAP_W-1:0]         left_gap;
   logic                     right_ok;
   logic signed [ICPT_W-1:0] right_intercept;
   logic signed [HEAD_W-1:0] right_heading;
   logic [GAP_W-1:0]         right_gap;

   modport source (output valid, left_ok, left_intercept, left_heading, left_gap,
                   right_ok, right_intercept, right_heading, right_gap, input ready);
   modport sink   (input valid, left_ok, left_intercept, left_heading, left_gap,
                   right_ok, right_intercept, right_heading, right_gap, output ready);
endinterface
`default_nettype wire

>>> src/wlr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_front
// Accepts readings, qualifies each pair and forms the line terms a, b, c.
// ----------------------------------------------------------------------------
module wlr_front import wlr_pkg::*; #(
   parameter int FRAC_BITS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wlr_req_if.sink                               req,
   input  wire cfg_type                          cfg,
   input  wire logic                             q_full,
   output logic                                  q_push,
   output logic [2*side_w(FRAC_BITS)-1:0]        q_data
);
   localparam int CSW = 18 + FRAC_BITS;
   localparam int AW  = CSW + 1;
   localparam int MB  = CSW;
   localparam int PW  = 2 * CSW;
   localparam int ACW = 2 * CSW + 1;
   localparam int SQ  = 2 * MB + 1;
   localparam int SW  = side_w(FRAC_BITS);

   function automatic logic signed [CSW-1:0] coord(input logic [RANGE_W-1:0] d,
                                                   input logic [14:0] k, input logic neg);
      logic [31:0]    p;
      logic [CSW-1:0] m;
      p = 32'(d) * 32'(k) + (32'd1 << (14 - FRAC_BITS));
      m = CSW'(p >> (15 - FRAC_BITS));
      return neg ? -m : m;
   endfunction

   function automatic logic reading_ok(input logic [RANGE_W-1:0] d, input cfg_type c);
      return (d > c.min_valid) && (d < c.max_range) && (d != c.err_code);
   endfunction

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [RANGE_W-1:0] d1 [2];
   logic [RANGE_W-1:0] d2 [2];
   logic [14:0]        k1x [2], k1y [2], k2x [2], k2y [2];
   logic               sneg [2];

   logic                  rok1_ff [2], rok2_ff [2], rok3_ff [2];
   logic signed [CSW-1:0] x1_ff [2], y1_ff [2], x2_ff [2], y2_ff [2];
   logic signed [AW-1:0]  a2s_ff [2], b2s_ff [2], a3_ff [2], b3_ff [2], a4_ff [2], b4_ff [2];
   logic signed [PW-1:0]  p1_ff [2], p2_ff [2];
   logic signed [ACW-1:0] c3_ff [2];
   logic [2*MB-1:0]       asq_ff [2], bsq_ff [2];
   logic [MB-1:0]         ab3_ff [2], ab4_ff [2];
   logic [ACW-1:0]        ac4_ff [2];
   logic [SQ-1:0]         sq4_ff [2];
   logic                  ok4_ff [2], neg4_ff [2];

   logic [RANGE_W-1:0]    diff [2];
   logic signed [2*AW-1:0] asq_full [2], bsq_full [2];

   assign en        = !(v4_ff && q_full);
   assign req.ready = en && !reset;
   assign q_push    = v4_ff && !q_full;

   always_comb begin
      d1[0] = req.left_far_range;   d2[0] = req.left_near_range;
      k1x[0] = K_SMALL; k1y[0] = K_BIG; k2x[0] = K_BIG; k2y[0] = K_SMALL; sneg[0] = 1'b1;
      d1[1] = req.right_near_range; d2[1] = req.right_far_range;
      k1x[1] = K_BIG; k1y[1] = K_SMALL; k2x[1] = K_SMALL; k2y[1] = K_BIG; sneg[1] = 1'b0;
      for (int s = 0; s < 2; s++) begin
         diff[s]     = (d1[s] > d2[s]) ? d1[s] - d2[s] : d2[s] - d1[s];
         asq_full[s] = a2s_ff[s] * a2s_ff[s];
         bsq_full[s] = b2s_ff[s] * b2s_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < 2; s++) begin
            // points
            rok1_ff[s] <= reading_ok(d1[s], cfg) && reading_ok(d2[s], cfg)
                          && (diff[s] <= cfg.max_diff);
            x1_ff[s]   <= coord(d1[s], k1x[s], 1'b0);
            y1_ff[s]   <= coord(d1[s], k1y[s], sneg[s]);
            x2_ff[s]   <= coord(d2[s], k2x[s], 1'b0);
            y2_ff[s]   <= coord(d2[s], k2y[s], sneg[s]);
            // a, b and cross products
            rok2_ff[s] <= rok1_ff[s];
            a2s_ff[s]  <= AW'(y2_ff[s]) - AW'(y1_ff[s]);
            b2s_ff[s]  <= AW'(x1_ff[s]) - AW'(x2_ff[s]);
            p1_ff[s]   <= x2_ff[s] * y1_ff[s];
            p2_ff[s]   <= x1_ff[s] * y2_ff[s];
            // c and squares
            rok3_ff[s] <= rok2_ff[s];
            a3_ff[s]   <= a2s_ff[s];
            b3_ff[s]   <= b2s_ff[s];
            c3_ff[s]   <= ACW'(p1_ff[s]) - ACW'(p2_ff[s]);
            asq_ff[s]  <= asq_full[s][2*MB-1:0];
            bsq_ff[s]  <= bsq_full[s][2*MB-1:0];
            ab3_ff[s]  <= b2s_ff[s][AW-1] ? MB'(-b2s_ff[s]) : MB'(b2s_ff[s]);
            // side qualification
            ok4_ff[s]  <= rok3_ff[s] && (ab3_ff[s] != '0) && (ab3_ff[s] >= MB'(cfg.vert_eps));
            neg4_ff[s] <= ((!c3_ff[s][ACW-1] && c3_ff[s] != '0) ==
                           (!b3_ff[s][AW-1] && b3_ff[s] != '0));
            a4_ff[s]   <= a3_ff[s];
            b4_ff[s]   <= b3_ff[s];
            ab4_ff[s]  <= ab3_ff[s];
            ac4_ff[s]  <= c3_ff[s][ACW-1] ? ACW'(-c3_ff[s]) : ACW'(c3_ff[s]);
            sq4_ff[s]  <= SQ'(asq_ff[s]) + SQ'(bsq_ff[s]);
         end
      end
   end

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         q_data[s*SW +: SW] = {ok4_ff[s], neg4_ff[s], a4_ff[s], b4_ff[s], ac4_ff[s],
                               ab4_ff[s], sq4_ff[s]};
      end
   end

endmodule
`default_nettype wire

>>> src/wlr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module wlr_fifo import wlr_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] wdata,
   input  wire logic         pop,
   output logic [W-1:0]      rdata,
   output q_stat_type        stat
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [NW-1:0] cnt_ff;

   assign stat.full  = (cnt_ff == NW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rdata      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wdata;
   end

endmodule
`default_nettype wire

>>> src/wlr_side.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_side
// Back end of one side: intercept divider, CORDIC heading, square root and
// gap divider, all pipelined and aligned to one output stage.
// ----------------------------------------------------------------------------
module wlr_side import wlr_pkg::*; #(
   parameter int FRAC_BITS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [side_w(FRAC_BITS)-1:0] word,
   output logic                             ok,
   output logic signed [ICPT_W-1:0]         intercept,
   output logic signed [HEAD_W-1:0]         heading,
   output logic [GAP_W-1:0]                 gap
);
   localparam int CSW  = 18 + FRAC_BITS;
   localparam int AW   = CSW + 1;
   localparam int MB   = CSW;
   localparam int ACW  = 2 * CSW + 1;
   localparam int SQ   = 2 * MB + 1;
   localparam int SQW  = 2 * MB + 14;
   localparam int RW   = SQW / 2;
   localparam int CW   = AW + 23;
   localparam int DW1  = (ACW + 1 > MB + ICPT_QB + 1) ? ACW + 1 : MB + ICPT_QB + 1;
   localparam int DW2  = (ACW + 7 > RW + GAP_QB + 1) ? ACW + 7 : RW + GAP_QB + 1;
   localparam int NREG = RW + 23;
   localparam int DLYI = NREG - ICPT_QB - 1;
   localparam int DLYH = NREG - CORDIC_N - 1;
   localparam int SENT = ((SENTINEL_MM << FRAC_BITS) > 1048575) ? 1048575
                                                               : (SENTINEL_MM << FRAC_BITS);

   logic                  ok_w, neg_w;
   logic signed [AW-1:0]  a_w, b_w;
   logic [ACW-1:0]        ac_w;
   logic [MB-1:0]         ab_w;
   logic [SQ-1:0]         sq_w;

   assign {ok_w, neg_w, a_w, b_w, ac_w, ab_w, sq_w} = word;

   // ok flag delay
   logic ok_ff [NREG];
   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff[0] <= ok_w;
         for (int i = 1; i < NREG; i++) ok_ff[i] <= ok_ff[i-1];
      end
   end

   // ---------------- intercept = round(|c| / |b|), restoring division
   logic [DW1-1:0]     irem_ff [ICPT_QB+1], irem_in [ICPT_QB+1];
   logic [MB-1:0]      idiv_ff [ICPT_QB+1];
   logic [ICPT_QB-1:0] iq_ff   [ICPT_QB+1], iq_in [ICPT_QB+1];
   logic               isat_ff [ICPT_QB+1], ineg_ff [ICPT_QB+1];
   logic               isat_w;
   logic [DW1-1:0]     idsh    [ICPT_QB];
   logic [ICPT_QB-1:0] imag;
   logic [ICPT_W-1:0]  ival;
   logic [ICPT_W-1:0]  idly_ff [DLYI];

   always_comb begin
      irem_in[0] = DW1'(ac_w) + DW1'(ab_w >> 1);
      iq_in[0]   = '0;
      isat_w     = irem_in[0] >= (DW1'(ab_w) << ICPT_QB);
      for (int j = 0; j < ICPT_QB; j++) begin
         idsh[j]      = DW1'(idiv_ff[j]) << (ICPT_QB - 1 - j);
         irem_in[j+1] = (irem_ff[j] >= idsh[j]) ? irem_ff[j] - idsh[j] : irem_ff[j];
         iq_in[j+1]   = {iq_ff[j][ICPT_QB-2:0], irem_ff[j] >= idsh[j]};
      end
      imag = isat_ff[ICPT_QB] ? INTERCEPT_MAX : iq_ff[ICPT_QB];
      ival = ineg_ff[ICPT_QB] ? -{1'b0, imag} : {1'b0, imag};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         isat_ff[0] <= isat_w;
         ineg_ff[0] <= neg_w;
         idiv_ff[0] <= ab_w;
         for (int j = 0; j <= ICPT_QB; j++) begin
            irem_ff[j] <= irem_in[j];
            iq_ff[j]   <= iq_in[j];
         end
         for (int j = 1; j <= ICPT_QB; j++) begin
            isat_ff[j] <= isat_ff[j-1];
            ineg_ff[j] <= ineg_ff[j-1];
            idiv_ff[j] <= idiv_ff[j-1];
         end
         idly_ff[0] <= ival;
         for (int j = 1; j < DLYI; j++) idly_ff[j] <= idly_ff[j-1];
      end
   end

   // ---------------- heading = atan2(a, -b), CORDIC vectoring
   logic signed [CW-1:0] cx_ff [CORDIC_N+1], cx_in [CORDIC_N+1];
   logic signed [CW-1:0] cy_ff [CORDIC_N+1], cy_in [CORDIC_N+1];
   logic signed [ZW-1:0] cz_ff [CORDIC_N+1], cz_in [CORDIC_N+1];
   logic signed [ZW-1:0] cb_ff [CORDIC_N+1], cb_in;
   logic signed [ZW:0]   ctot;
   logic signed [ZW-10:0] cshift;
   logic [HEAD_W-1:0]    hval;
   logic [HEAD_W-1:0]    hdly_ff [DLYH];

   always_comb begin
      // x = -b; when x < 0 rotate by half a turn
      if (!b_w[AW-1] && b_w != '0) begin
         cb_in    = a_w[AW-1] ? -ZW'(HALF_TURN) : ZW'(HALF_TURN);
         cx_in[0] = CW'(b_w) <<< 20;
         cy_in[0] = -(CW'(a_w) <<< 20);
      end else begin
         cb_in    = '0;
         cx_in[0] = -(CW'(b_w) <<< 20);
         cy_in[0] = CW'(a_w) <<< 20;
      end
      cz_in[0] = '0;
      for (int i = 0; i < CORDIC_N; i++) begin
         if (!cy_ff[i][CW-1] && cy_ff[i] != '0) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + ZW'(atan_entry(4'(i)));
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - ZW'(atan_entry(4'(i)));
         end
      end
      ctot   = (ZW+1)'(cb_ff[CORDIC_N]) + (ZW+1)'(cz_ff[CORDIC_N]) + (ZW+1)'(512);
      cshift = (ZW-9)'(ctot >>> 10);
      if (cshift > (ZW-9)'(HEADING_MAX))       hval = HEAD_W'(HEADING_MAX);
      else if (cshift < -(ZW-9)'(HEADING_MAX)) hval = HEAD_W'(-HEADING_MAX);
      else                                     hval = HEAD_W'(cshift);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cb_ff[0] <= cb_in;
         for (int i = 0; i <= CORDIC_N; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
         end
         for (int i = 1; i <= CORDIC_N; i++) cb_ff[i] <= cb_ff[i-1];
         hdly_ff[0] <= hval;
         for (int i = 1; i < DLYH; i++) hdly_ff[i] <= hdly_ff[i-1];
      end
   end

   // ---------------- s = isqrt((a^2 + b^2) << 12), two bits a stage
   logic [SQW-1:0]  sv_ff [RW+1], sv_in [RW+1];
   logic [RW+1:0]   sr_ff [RW+1], sr_in [RW+1];
   logic [RW-1:0]   ss_ff [RW+1], ss_in [RW+1];
   logic [ACW-1:0]  sac_ff [RW+1];
   logic [RW+3:0]   scur [RW], strial [RW];

   always_comb begin
      sv_in[0] = SQW'(sq_w) << 12;
      sr_in[0] = '0;
      ss_in[0] = '0;
      for (int i = 0; i < RW; i++) begin
         scur[i]    = {sr_ff[i], sv_ff[i][SQW-1 -: 2]};
         strial[i]  = scur[i] - (RW+4)'({ss_ff[i], 2'b01});
         sv_in[i+1] = sv_ff[i] << 2;
         if (!strial[i][RW+3]) begin
            sr_in[i+1] = strial[i][RW+1:0];
            ss_in[i+1] = {ss_ff[i][RW-2:0], 1'b1};
         end else begin
            sr_in[i+1] = scur[i][RW+1:0];
            ss_in[i+1] = {ss_ff[i][RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sac_ff[0] <= ac_w;
         for (int i = 0; i <= RW; i++) begin
            sv_ff[i] <= sv_in[i];
            sr_ff[i] <= sr_in[i];
            ss_ff[i] <= ss_in[i];
         end
         for (int i = 1; i <= RW; i++) sac_ff[i] <= sac_ff[i-1];
      end
   end

   // ---------------- gap = round(|c| * 64 / s)
   logic [DW2-1:0]    grem_ff [GAP_QB+1], grem_in [GAP_QB+1];
   logic [RW-1:0]     gdiv_ff [GAP_QB+1];
   logic [GAP_QB-1:0] gq_ff   [GAP_QB+1], gq_in [GAP_QB+1];
   logic              gsat_ff [GAP_QB+1], gzero_ff [GAP_QB+1];
   logic [DW2-1:0]    gdsh    [GAP_QB];
   logic [RW-1:0]     groot;
   logic [GAP_W-1:0]  gout_ff;

   always_comb begin
      groot      = ss_ff[RW];
      grem_in[0] = (DW2'(sac_ff[RW]) << 6) + DW2'(groot >> 1);
      gq_in[0]   = '0;
      for (int j = 0; j < GAP_QB; j++) begin
         gdsh[j]      = DW2'(gdiv_ff[j]) << (GAP_QB - 1 - j);
         grem_in[j+1] = (grem_ff[j] >= gdsh[j]) ? grem_ff[j] - gdsh[j] : grem_ff[j];
         gq_in[j+1]   = {gq_ff[j][GAP_QB-2:0], grem_ff[j] >= gdsh[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gdiv_ff[0]  <= groot;
         gzero_ff[0] <= (groot == '0);
         gsat_ff[0]  <= grem_in[0] >= (DW2'(groot) << GAP_QB);
         for (int j = 0; j <= GAP_QB; j++) begin
            grem_ff[j] <= grem_in[j];
            gq_ff[j]   <= gq_in[j];
         end
         for (int j = 1; j <= GAP_QB; j++) begin
            gdiv_ff[j]  <= gdiv_ff[j-1];
            gzero_ff[j] <= gzero_ff[j-1];
            gsat_ff[j]  <= gsat_ff[j-1];
         end
         if (gzero_ff[GAP_QB])     gout_ff <= GAP_W'(SENT);
         else if (gsat_ff[GAP_QB]) gout_ff <= GAP_MAX;
         else                      gout_ff <= GAP_W'(gq_ff[GAP_QB]);
      end
   end

   // invalid side reports zeros
   assign ok        = ok_ff[NREG-1];
   assign intercept = ok ? idly_ff[DLYI-1] : '0;
   assign heading   = ok ? hdly_ff[DLYH-1] : '0;
   assign gap       = ok ? gout_ff : '0;

endmodule
`default_nettype wire

>>> src/wall_line_from_range_pairs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wall_line_from_range_pairs
// Fits a wall line on each side from two range readings and reports the
// intercept, heading and distance of each line.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   four 16-bit ranges, mm
//  rsp      out  valid/ready   per side ok, intercept, heading, gap
//  csr      in   csr_we        csr_index selects register, csr_wdata 16 bits
//
//  One word per cycle sustained while rsp is ready. The path runs through 4
//  front stages, the queue and FRAC_BITS + 48 back stages; the back length is
//  set by the square root (one root bit a stage) followed by the gap divider.
//  Synchronous active-high reset clears valids and queue and loads register defaults.
//  A stalled rsp holds the back pipe; the queue then fills and req stalls.
// ----------------------------------------------------------------------------
module wall_line_from_range_pairs import wlr_pkg::*; #(
   parameter int FRAC_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   wlr_req_if.sink                   req,
   wlr_rsp_if.source                 rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [RANGE_W-1:0]   csr_wdata
);
   localparam int SW   = side_w(FRAC_BITS);
   localparam int NREG = FRAC_BITS + 48;

   cfg_type    cfg_ff;
   logic       q_push, q_pop, en_b;
   logic [2*SW-1:0] q_wdata, q_rdata;
   q_stat_type q_stat;
   logic       vld_ff [NREG];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid <= 16'd20;
         cfg_ff.max_range <= 16'd2000;
         cfg_ff.err_code  <= 16'd65535;
         cfg_ff.max_diff  <= 16'd500;
         cfg_ff.vert_eps  <= 16'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_MIN_VALID: cfg_ff.min_valid <= csr_wdata;
            CFG_MAX_RANGE: cfg_ff.max_range <= csr_wdata;
            CFG_ERR_CODE:  cfg_ff.err_code  <= csr_wdata;
            CFG_MAX_DIFF:  cfg_ff.max_diff  <= csr_wdata;
            CFG_VERT_EPS:  cfg_ff.vert_eps  <= csr_wdata;
            default: ;
         endcase
      end
   end

   wlr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg_ff),
      .q_full (q_stat.full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   wlr_fifo #(.W(2*SW), .DEPTH(4)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // back pipe moves unless a finished word is waiting
   assign en_b      = !vld_ff[NREG-1] || rsp.ready;
   assign q_pop     = en_b && !q_stat.empty;
   assign rsp.valid = vld_ff[NREG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) vld_ff[i] <= 1'b0;
      end else if (en_b) begin
         vld_ff[0] <= !q_stat.empty;
         for (int i = 1; i < NREG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   wlr_side #(.FRAC_BITS(FRAC_BITS)) u_left (
      .clock     (clock),
      .en        (en_b),
      .word      (q_rdata[0 +: SW]),
      .ok        (rsp.left_ok),
      .intercept (rsp.left_intercept),
      .heading   (rsp.left_heading),
      .gap       (rsp.left_gap)
   );

   wlr_side #(.FRAC_BITS(FRAC_BITS)) u_right (
      .clock     (clock),
      .en        (en_b),
      .word      (q_rdata[SW +: SW]),
      .ok        (rsp.right_ok),
      .intercept (rsp.right_intercept),
      .heading   (rsp.right_heading),
      .gap       (rsp.right_gap)
   );

endmodule
`default_nettype wire
